[rtl/cpcr_pkg.sv]
package cpcr_pkg;

   localparam int FIELD_W     = 24;
   localparam int NUM_FIELDS  = 8;
   localparam int CSR_W       = 16;
   localparam int DIST_W      = CSR_W + 1;
   localparam int D2_W        = 2 * (FIELD_W + 1);
   localparam int MSQ_W       = 2 * DIST_W;
   localparam int SQRT_STAGES = DIST_W;
   localparam int DIV_STAGES  = DIST_W;
   localparam int NORM_W      = DIST_W + 1;
   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);
   localparam int SAT_W       = 35;

   // field order of the item
   localparam int F_P1X = 0;
   localparam int F_P1Y = 1;
   localparam int F_V1X = 2;
   localparam int F_V1Y = 3;
   localparam int F_P2X = 4;
   localparam int F_P2Y = 5;
   localparam int F_V2X = 6;
   localparam int F_V2Y = 7;

   typedef enum logic [1:0] {
      CSR_RADIUS      = 2'd0,
      CSR_RESTITUTION = 2'd1,
      CSR_DAMPING     = 2'd2
   } cpcr_csr_type;

   typedef enum logic [1:0] {
      ST_NONE     = 2'd0,
      ST_SEPARATE = 2'd1,
      ST_RESOLVED = 2'd2
   } cpcr_status_type;

   typedef logic [NUM_FIELDS-1:0][FIELD_W-1:0] cpcr_vals_type;

   typedef struct packed {
      cpcr_vals_type      vals;
      logic               contact;
      logic signed [24:0] dx;
      logic signed [24:0] dy;
   } cpcr_tag_type;

   typedef struct packed {
      cpcr_vals_type             vals;
      logic                      contact;
      logic [DIST_W-1:0]         centre_dist;
      logic signed [NORM_W-1:0]  nx;
      logic signed [NORM_W-1:0]  ny;
   } cpcr_work_type;

   function automatic logic [FIELD_W-1:0] sat_field(input logic signed [SAT_W-1:0] v);
      logic signed [SAT_W-1:0] hi;
      logic signed [SAT_W-1:0] lo;
      hi = SAT_W'(signed'(25'sd8388607));
      lo = -SAT_W'(signed'(25'sd8388608));
      if (v > hi) begin
         return 24'h7FFFFF;
      end else if (v < lo) begin
         return 24'h800000;
      end
      return v[FIELD_W-1:0];
   endfunction

endpackage

[rtl/cpcr_isqrt.sv]
module cpcr_isqrt
   import cpcr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [MSQ_W-1:0]  in_n,
   input  cpcr_tag_type      in_tag,
   output logic              out_valid,
   output logic [DIST_W-1:0] out_root,
   output cpcr_tag_type      out_tag
);

   logic [SQRT_STAGES:1]  vld_ff;
   logic [DIST_W+1:0]     rem_ff  [1:SQRT_STAGES];
   logic [DIST_W-1:0]     root_ff [1:SQRT_STAGES];
   logic [MSQ_W-1:0]      n_ff    [1:SQRT_STAGES];
   cpcr_tag_type          tag_ff  [1:SQRT_STAGES];

   for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
      localparam int K = SQRT_STAGES - 1 - s;
      logic                vld_p;
      logic [DIST_W+1:0]   rem_p;
      logic [DIST_W-1:0]   root_p;
      logic [MSQ_W-1:0]    n_p;
      cpcr_tag_type        tag_p;
      logic [DIST_W+3:0]   rem_t;
      logic [DIST_W+3:0]   test;
      logic [DIST_W+3:0]   diff;
      logic [DIST_W+1:0]   rem_in;
      logic [DIST_W-1:0]   root_in;

      if (s == 0) begin : g_first
         assign vld_p  = in_valid;
         assign rem_p  = '0;
         assign root_p = '0;
         assign n_p    = in_n;
         assign tag_p  = in_tag;
      end else begin : g_next
         assign vld_p  = vld_ff[s];
         assign rem_p  = rem_ff[s];
         assign root_p = root_ff[s];
         assign n_p    = n_ff[s];
         assign tag_p  = tag_ff[s];
      end

      // bring down the next two bits and try the new root bit
      always_comb begin
         rem_t = {rem_p, n_p[2*K+1 -: 2]};
         test  = {2'b00, root_p, 2'b01};
         diff  = rem_t - test;
         if (rem_t >= test) begin
            rem_in  = diff[DIST_W+1:0];
            root_in = {root_p[DIST_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_t[DIST_W+1:0];
            root_in = {root_p[DIST_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s+1] <= 1'b0;
         end else begin
            vld_ff[s+1] <= vld_p;
         end
         rem_ff[s+1]  <= rem_in;
         root_ff[s+1] <= root_in;
         n_ff[s+1]    <= n_p;
         tag_ff[s+1]  <= tag_p;
      end
   end

   assign out_valid = vld_ff[SQRT_STAGES];
   assign out_root  = root_ff[SQRT_STAGES];
   assign out_tag   = tag_ff[SQRT_STAGES];

endmodule

[rtl/cpcr_div.sv]
module cpcr_div
   import cpcr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [DIST_W-1:0] in_dist,
   input  cpcr_tag_type      in_tag,
   output logic              out_valid,
   output cpcr_work_type     out_work
);

   logic [DIV_STAGES:1]   vld_ff;
   logic [DIST_W-1:0]     rx_ff   [1:DIV_STAGES];
   logic [DIST_W-1:0]     ry_ff   [1:DIV_STAGES];
   logic [DIST_W-1:0]     qx_ff   [1:DIV_STAGES];
   logic [DIST_W-1:0]     qy_ff   [1:DIV_STAGES];
   logic [DIST_W-1:0]     dist_ff [1:DIV_STAGES];
   cpcr_tag_type          tag_ff  [1:DIV_STAGES];

   logic [24:0] mag_x;
   logic [24:0] mag_y;

   // the normal's magnitude never exceeds the distance, so its low bits suffice
   assign mag_x = in_tag.dx[24] ? 25'(-in_tag.dx) : in_tag.dx;
   assign mag_y = in_tag.dy[24] ? 25'(-in_tag.dy) : in_tag.dy;

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      logic              vld_p;
      logic [DIST_W:0]   tx;
      logic [DIST_W:0]   ty;
      logic [DIST_W-1:0] qx_p;
      logic [DIST_W-1:0] qy_p;
      logic [DIST_W-1:0] d_p;
      cpcr_tag_type      tag_p;
      logic              gex;
      logic              gey;
      logic [DIST_W:0]   sx;
      logic [DIST_W:0]   sy;

      if (s == 0) begin : g_first
         assign vld_p = in_valid;
         assign tx    = {1'b0, mag_x[DIST_W-1:0]};
         assign ty    = {1'b0, mag_y[DIST_W-1:0]};
         assign qx_p  = '0;
         assign qy_p  = '0;
         assign d_p   = in_dist;
         assign tag_p = in_tag;
      end else begin : g_next
         assign vld_p = vld_ff[s];
         assign tx    = {rx_ff[s], 1'b0};
         assign ty    = {ry_ff[s], 1'b0};
         assign qx_p  = qx_ff[s];
         assign qy_p  = qy_ff[s];
         assign d_p   = dist_ff[s];
         assign tag_p = tag_ff[s];
      end

      always_comb begin
         gex = tx >= {1'b0, d_p};
         gey = ty >= {1'b0, d_p};
         sx  = gex ? tx - {1'b0, d_p} : tx;
         sy  = gey ? ty - {1'b0, d_p} : ty;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s+1] <= 1'b0;
         end else begin
            vld_ff[s+1] <= vld_p;
         end
         rx_ff[s+1]   <= sx[DIST_W-1:0];
         ry_ff[s+1]   <= sy[DIST_W-1:0];
         qx_ff[s+1]   <= {qx_p[DIST_W-2:0], gex};
         qy_ff[s+1]   <= {qy_p[DIST_W-2:0], gey};
         dist_ff[s+1] <= d_p;
         tag_ff[s+1]  <= tag_p;
      end
   end

   always_comb begin
      logic signed [NORM_W-1:0] qx;
      logic signed [NORM_W-1:0] qy;
      qx = $signed({1'b0, qx_ff[DIV_STAGES]});
      qy = $signed({1'b0, qy_ff[DIV_STAGES]});
      out_work.vals        = tag_ff[DIV_STAGES].vals;
      out_work.contact     = tag_ff[DIV_STAGES].contact;
      out_work.centre_dist = dist_ff[DIV_STAGES];
      // truncate toward zero: divide magnitudes, then restore the sign
      out_work.nx          = tag_ff[DIV_STAGES].dx[24] ? -qx : qx;
      out_work.ny          = tag_ff[DIV_STAGES].dy[24] ? -qy : qy;
   end

   assign out_valid = vld_ff[DIV_STAGES];

endmodule

[rtl/cpcr_front.sv]
module cpcr_front
   import cpcr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  cpcr_vals_type     in_vals,
   input  logic [CSR_W-1:0]  radius,
   output logic              out_valid,
   output cpcr_work_type     out_work
);

   logic               vld0_ff, vld1_ff, vld2_ff;
   cpcr_tag_type       tag0_ff, tag1_ff, tag2_ff;
   logic [D2_W-3:0]    dx2_ff, dy2_ff;
   logic [D2_W-1:0]    d2_ff;
   logic [MSQ_W-1:0]   msq_ff;
   logic [DIST_W-1:0]  min_dist;
   cpcr_tag_type       cls_tag;
   logic               sq_valid;
   logic [DIST_W-1:0]  sq_root;
   cpcr_tag_type       sq_tag;

   assign min_dist = {radius, 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else begin
         vld0_ff <= in_valid;
         vld1_ff <= vld0_ff;
         vld2_ff <= vld1_ff;
      end
      msq_ff       <= min_dist * min_dist;
      tag0_ff.vals <= in_vals;
      tag0_ff.contact <= 1'b0;
      tag0_ff.dx   <= $signed({in_vals[F_P2X][FIELD_W-1], in_vals[F_P2X]})
                    - $signed({in_vals[F_P1X][FIELD_W-1], in_vals[F_P1X]});
      tag0_ff.dy   <= $signed({in_vals[F_P2Y][FIELD_W-1], in_vals[F_P2Y]})
                    - $signed({in_vals[F_P1Y][FIELD_W-1], in_vals[F_P1Y]});
      tag1_ff      <= tag0_ff;
      dx2_ff       <= (D2_W-2)'(tag0_ff.dx * tag0_ff.dx);
      dy2_ff       <= (D2_W-2)'(tag0_ff.dy * tag0_ff.dy);
      tag2_ff      <= tag1_ff;
      d2_ff        <= {2'b00, dx2_ff} + {2'b00, dy2_ff};
   end

   // contact iff d2 is nonzero and floor(sqrt(d2)) < 2R, i.e. 0 < d2 < (2R)^2
   always_comb begin
      cls_tag         = tag2_ff;
      cls_tag.contact = (d2_ff != '0) && (d2_ff < {{(D2_W-MSQ_W){1'b0}}, msq_ff});
   end

   cpcr_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld2_ff),
      .in_n      (d2_ff[MSQ_W-1:0]),
      .in_tag    (cls_tag),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_tag   (sq_tag)
   );

   cpcr_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_dist   (sq_root),
      .in_tag    (sq_tag),
      .out_valid (out_valid),
      .out_work  (out_work)
   );

endmodule

[rtl/cpcr_fifo.sv]
module cpcr_fifo
   import cpcr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  cpcr_work_type push_data,
   input  logic          pop,
   output logic          empty,
   output logic          full,
   output logic          rd_valid,
   output cpcr_work_type rd_data
);

   cpcr_work_type         mem [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   logic                  rd_valid_ff;
   cpcr_work_type         rd_data_ff;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == FIFO_CNT_W'(FIFO_DEPTH));

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         count_ff    <= count_in;
         rd_valid_ff <= pop;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
      if (pop) begin
         rd_data_ff <= mem[rd_ptr_ff];
      end
   end

   assign rd_valid = rd_valid_ff;
   assign rd_data  = rd_data_ff;

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("item pushed into full queue");

   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("item popped from empty queue");

   a_count_grows : assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue fill count lost an item");

endmodule

[rtl/cpcr_back.sv]
module cpcr_back
   import cpcr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  cpcr_work_type         in_work,
   input  logic [CSR_W-1:0]      radius,
   input  logic [CSR_W-1:0]      restitution,
   input  logic [CSR_W-1:0]      damping,
   output logic                  out_valid,
   output cpcr_vals_type         out_vals,
   output cpcr_status_type       out_status
);

   // stage 1: relative velocity and overlap products
   logic                     v1_ff;
   cpcr_vals_type            vals1_ff;
   logic                     con1_ff;
   logic signed [NORM_W-1:0] nx1_ff, ny1_ff;
   logic signed [42:0]       pvx1_ff, pvy1_ff;
   logic signed [36:0]       ppx1_ff, ppy1_ff;
   // stage 2
   logic                     v2_ff;
   cpcr_vals_type            vals2_ff;
   logic                     con2_ff, clo2_ff;
   logic signed [NORM_W-1:0] nx2_ff, ny2_ff;
   logic signed [45:0]       tp2_ff;
   logic signed [19:0]       px2_ff, py2_ff;
   // stage 3
   logic                     v3_ff;
   cpcr_vals_type            vals3_ff;
   logic                     con3_ff, clo3_ff;
   logic signed [NORM_W-1:0] nx3_ff, ny3_ff;
   logic signed [46:0]       jp3_ff;
   logic signed [19:0]       px3_ff, py3_ff;
   // stage 4
   logic                     v4_ff;
   cpcr_vals_type            vals4_ff;
   logic                     con4_ff, clo4_ff;
   logic signed [49:0]       ixp4_ff, iyp4_ff;
   logic signed [19:0]       px4_ff, py4_ff;
   // output
   logic                     vo_ff;
   cpcr_vals_type            valso_ff;
   cpcr_status_type          sto_ff;

   logic signed [24:0]       rvx, rvy;
   logic signed [18:0]       ovl;
   logic signed [43:0]       vnq;
   logic signed [27:0]       vn;
   logic signed [17:0]       rest_s;
   logic signed [29:0]       tt;
   logic signed [16:0]       damp_s;
   logic signed [31:0]       jj;

   cpcr_vals_type            vals_in;
   cpcr_status_type          st_in;

   always_comb begin
      rvx    = $signed({in_work.vals[F_V2X][FIELD_W-1], in_work.vals[F_V2X]})
             - $signed({in_work.vals[F_V1X][FIELD_W-1], in_work.vals[F_V1X]});
      rvy    = $signed({in_work.vals[F_V2Y][FIELD_W-1], in_work.vals[F_V2Y]})
             - $signed({in_work.vals[F_V1Y][FIELD_W-1], in_work.vals[F_V1Y]});
      ovl    = $signed({2'b00, radius, 1'b0}) - $signed({2'b00, in_work.centre_dist});
      vnq    = 44'(pvx1_ff) + 44'(pvy1_ff);
      vn     = vnq[43:16];
      rest_s = $signed({2'b01, restitution});
      tt     = tp2_ff[45:16];
      damp_s = $signed({1'b0, damping});
      jj     = -32'($signed(jp3_ff[46:16]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         vo_ff <= v4_ff;
      end

      vals1_ff <= in_work.vals;
      con1_ff  <= in_work.contact;
      nx1_ff   <= in_work.nx;
      ny1_ff   <= in_work.ny;
      pvx1_ff  <= rvx * in_work.nx;
      pvy1_ff  <= rvy * in_work.ny;
      ppx1_ff  <= in_work.nx * ovl;
      ppy1_ff  <= in_work.ny * ovl;

      vals2_ff <= vals1_ff;
      con2_ff  <= con1_ff;
      clo2_ff  <= (vnq <= 44'sd0);
      nx2_ff   <= nx1_ff;
      ny2_ff   <= ny1_ff;
      tp2_ff   <= vn * rest_s;
      px2_ff   <= ppx1_ff[36:17];
      py2_ff   <= ppy1_ff[36:17];

      vals3_ff <= vals2_ff;
      con3_ff  <= con2_ff;
      clo3_ff  <= clo2_ff;
      nx3_ff   <= nx2_ff;
      ny3_ff   <= ny2_ff;
      jp3_ff   <= tt * damp_s;
      px3_ff   <= px2_ff;
      py3_ff   <= py2_ff;

      vals4_ff <= vals3_ff;
      con4_ff  <= con3_ff;
      clo4_ff  <= clo3_ff;
      ixp4_ff  <= jj * nx3_ff;
      iyp4_ff  <= jj * ny3_ff;
      px4_ff   <= px3_ff;
      py4_ff   <= py3_ff;

      valso_ff <= vals_in;
      sto_ff   <= st_in;
   end

   function automatic logic signed [SAT_W-1:0] wide(input logic [FIELD_W-1:0] f);
      return SAT_W'($signed(f));
   endfunction

   // apply impulse and push only for a resolved pair
   always_comb begin
      logic signed [SAT_W-1:0] ix;
      logic signed [SAT_W-1:0] iy;
      logic signed [SAT_W-1:0] px;
      logic signed [SAT_W-1:0] py;
      ix = SAT_W'($signed(ixp4_ff[49:16]));
      iy = SAT_W'($signed(iyp4_ff[49:16]));
      px = SAT_W'(px4_ff);
      py = SAT_W'(py4_ff);
      vals_in = vals4_ff;
      st_in   = ST_NONE;
      if (con4_ff) begin
         if (!clo4_ff) begin
            st_in = ST_SEPARATE;
         end else begin
            st_in          = ST_RESOLVED;
            vals_in[F_V1X] = sat_field(wide(vals4_ff[F_V1X]) - ix);
            vals_in[F_V1Y] = sat_field(wide(vals4_ff[F_V1Y]) - iy);
            vals_in[F_V2X] = sat_field(wide(vals4_ff[F_V2X]) + ix);
            vals_in[F_V2Y] = sat_field(wide(vals4_ff[F_V2Y]) + iy);
            vals_in[F_P1X] = sat_field(wide(vals4_ff[F_P1X]) - px);
            vals_in[F_P1Y] = sat_field(wide(vals4_ff[F_P1Y]) - py);
            vals_in[F_P2X] = sat_field(wide(vals4_ff[F_P2X]) + px);
            vals_in[F_P2Y] = sat_field(wide(vals4_ff[F_P2Y]) + py);
         end
      end
   end

   assign out_valid  = vo_ff;
   assign out_vals   = valso_ff;
   assign out_status = sto_ff;

endmodule

[rtl/circle_pair_collision_resolve_unit.sv]
// Collision response for a pair of equal circles.
//
// Input: pulse start with the eight req_ fields (positions and velocities of
// both circles, signed fixed point). An item is taken at every edge where
// start is high and busy is low; busy stays low in normal use, so one pair
// may be issued every cycle.
// Output: rsp_valid is high for one cycle with the updated fields and
// rsp_contact_status. Results leave in issue order, one per cycle at most.
// The path from start to rsp_valid runs through difference and squaring,
// a pipelined square root (one root bit a stage), a pipelined normal
// division (one quotient bit a stage), the queue between classifier and
// response datapath, and multiply and saturate. Throughput is one item per
// cycle while busy is low.
// Configuration: csr_write_en, csr_index and csr_data write one of the radius,
// restitution and damping registers per write; write them only while idle.
// Reset: synchronous, active high; empties all stages and the queue and
// loads the default radius, restitution and damping.
// rsp_valid cannot be held off; the receiver must take each result.
module circle_pair_collision_resolve_unit
   import cpcr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [23:0] req_first_pos_x,
   input  logic signed [23:0] req_first_pos_y,
   input  logic signed [23:0] req_first_vel_x,
   input  logic signed [23:0] req_first_vel_y,
   input  logic signed [23:0] req_second_pos_x,
   input  logic signed [23:0] req_second_pos_y,
   input  logic signed [23:0] req_second_vel_x,
   input  logic signed [23:0] req_second_vel_y,
   output logic               rsp_valid,
   output logic signed [23:0] rsp_new_first_pos_x,
   output logic signed [23:0] rsp_new_first_pos_y,
   output logic signed [23:0] rsp_new_first_vel_x,
   output logic signed [23:0] rsp_new_first_vel_y,
   output logic signed [23:0] rsp_new_second_pos_x,
   output logic signed [23:0] rsp_new_second_pos_y,
   output logic signed [23:0] rsp_new_second_vel_x,
   output logic signed [23:0] rsp_new_second_vel_y,
   output logic [1:0]         rsp_contact_status,
   input  logic               csr_write_en,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_data
);

   logic [CSR_W-1:0] radius_ff, restitution_ff, damping_ff;
   logic             accept;
   cpcr_vals_type    in_vals;
   logic             fr_valid;
   cpcr_work_type    fr_work;
   logic             q_empty, q_full, q_valid;
   cpcr_work_type    q_data;
   cpcr_vals_type    out_vals;
   cpcr_status_type  out_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff      <= 16'd2560;
         restitution_ff <= 16'd52429;
         damping_ff     <= 16'd58982;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_RADIUS:      radius_ff      <= csr_data;
            CSR_RESTITUTION: restitution_ff <= csr_data;
            CSR_DAMPING:     damping_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   assign busy   = q_full;
   assign accept = start && !busy;

   always_comb begin
      in_vals        = '0;
      in_vals[F_P1X] = req_first_pos_x;
      in_vals[F_P1Y] = req_first_pos_y;
      in_vals[F_V1X] = req_first_vel_x;
      in_vals[F_V1Y] = req_first_vel_y;
      in_vals[F_P2X] = req_second_pos_x;
      in_vals[F_P2Y] = req_second_pos_y;
      in_vals[F_V2X] = req_second_vel_x;
      in_vals[F_V2Y] = req_second_vel_y;
   end

   cpcr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_vals   (in_vals),
      .radius    (radius_ff),
      .out_valid (fr_valid),
      .out_work  (fr_work)
   );

   cpcr_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fr_valid),
      .push_data (fr_work),
      .pop       (!q_empty),
      .empty     (q_empty),
      .full      (q_full),
      .rd_valid  (q_valid),
      .rd_data   (q_data)
   );

   cpcr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (q_valid),
      .in_work     (q_data),
      .radius      (radius_ff),
      .restitution (restitution_ff),
      .damping     (damping_ff),
      .out_valid   (rsp_valid),
      .out_vals    (out_vals),
      .out_status  (out_status)
   );

   assign rsp_new_first_pos_x  = out_vals[F_P1X];
   assign rsp_new_first_pos_y  = out_vals[F_P1Y];
   assign rsp_new_first_vel_x  = out_vals[F_V1X];
   assign rsp_new_first_vel_y  = out_vals[F_V1Y];
   assign rsp_new_second_pos_x = out_vals[F_P2X];
   assign rsp_new_second_pos_y = out_vals[F_P2Y];
   assign rsp_new_second_vel_x = out_vals[F_V2X];
   assign rsp_new_second_vel_y = out_vals[F_V2Y];
   assign rsp_contact_status   = out_status;

endmodule
